// ===== rtl/bba_pkg.sv =====
package bba_pkg;

    // map geometry
    localparam int MAP_BYTES   = 512;
    localparam int TOTAL_BITS  = MAP_BYTES * 8;
    localparam int GRANT_LIMIT = 4096;
    localparam int LIMIT_BITS  = (TOTAL_BITS < GRANT_LIMIT) ? TOTAL_BITS : GRANT_LIMIT;

    // storage word of the bitmap memory
    localparam int WORD_W     = 64;
    localparam int BIT_W      = 6;
    localparam int NUM_WORDS  = (TOTAL_BITS + WORD_W - 1) / WORD_W;
    localparam int SCAN_WORDS = (LIMIT_BITS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SCNT_W     = $clog2(SCAN_WORDS + 1);

    // field widths
    localparam int ACT_W   = 2;
    localparam int BLOCK_W = 12;
    localparam int STAT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FORMAT = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // result of the lowest-set-bit unit
    typedef struct packed {
        logic              hit;
        logic [BIT_W-1:0]  idx;
        logic [WORD_W-1:0] cleared;
    } bf_res_t;

    // formatted contents of one memory word
    function automatic logic [WORD_W-1:0] format_word(input logic [WADDR_W-1:0] addr);
        logic [WORD_W-1:0] w;
        int                base;
        base = int'(addr) * WORD_W;
        for (int i = 0; i < WORD_W; i++) begin
            w[i] = ((base + i) < TOTAL_BITS) && !((base == 0) && (i < 2));
        end
        return w;
    endfunction

endpackage

// ===== rtl/bitmap_block_allocator.sv =====
// allocate: the scan reads the 64-bit words in order up to the word that holds the first free block,
//   or through every word with a full map; free reads and rewrites one word (none when out of range)
// throughput: one request at a time, set by the word-per-cycle bitmap scan
//   through the single read port of the 64 x 64-bit map memory
// reset: aresetn low clears control; afterwards a pass over every word writes the
//   formatted map (all free but blocks 0 and 1) before the first request is taken
module bitmap_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] block_number, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] granted_block, [15:12] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    // request and result holding
    logic [bba_pkg::BLOCK_W-1:0] blk_reg, blk_next;
    logic [bba_pkg::BLOCK_W-1:0] res_grant_reg, res_grant_next;
    logic [bba_pkg::STAT_W-1:0]  res_status_reg, res_status_next;
    logic                        fmt_resp_reg, fmt_resp_next;

    // sweep and scan counters
    logic [bba_pkg::WADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [bba_pkg::SCNT_W-1:0]  issue_reg, issue_next;
    logic [bba_pkg::WADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic                        pend_valid_reg, pend_valid_next;

    // output register
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [bba_pkg::BLOCK_W-1:0] m_grant_reg, m_grant_next;
    logic [bba_pkg::STAT_W-1:0]  m_status_reg, m_status_next;

    // map memory port
    logic                        ram_we, ram_re;
    logic [bba_pkg::WADDR_W-1:0] ram_waddr, ram_raddr;
    logic [bba_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;

    // lowest free bit search
    logic [bba_pkg::WORD_W-1:0]    scan_word;
    bba_pkg::bf_res_t              bf;
    logic [bba_pkg::WADDR_W+bba_pkg::BIT_W-1:0] hit_block;
    logic [bba_pkg::BLOCK_W-1:0]   free_blk;
    logic [bba_pkg::WORD_W-1:0]    free_bit;

    bba_ram #(
        .WIDTH(bba_pkg::WORD_W),
        .DEPTH(bba_pkg::NUM_WORDS)
    ) u_map (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // block 0 is never granted: hide its bit in word 0
    assign scan_word = (pend_addr_reg == '0)
                     ? (ram_rdata & ~bba_pkg::WORD_W'(1)) : ram_rdata;

    bba_bitfind u_find (
        .word(scan_word),
        .res (bf)
    );

    assign hit_block = {pend_addr_reg, bf.idx};
    assign free_blk  = s_tdata[bba_pkg::BLOCK_W-1:0];
    assign free_bit  = bba_pkg::WORD_W'(1) << blk_reg[bba_pkg::BIT_W-1:0];

    always_comb begin
        state_next      = state_reg;
        blk_next        = blk_reg;
        res_grant_next  = res_grant_reg;
        res_status_next = res_status_reg;
        fmt_resp_next   = fmt_resp_reg;
        clr_addr_next   = clr_addr_reg;
        issue_next      = issue_reg;
        pend_addr_next  = pend_addr_reg;
        pend_valid_next = pend_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_grant_next    = m_grant_reg;
        m_status_next   = m_status_reg;

        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = bba_pkg::format_word(clr_addr_reg);
        ram_re    = 1'b0;
        ram_raddr = bba_pkg::WADDR_W'(issue_reg);

        unique case (state_reg)
            // write formatted words, one per cycle
            S_CLEAR: begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + bba_pkg::WADDR_W'(1);
                if (clr_addr_reg == bba_pkg::WADDR_W'(bba_pkg::NUM_WORDS - 1)) begin
                    clr_addr_next = '0;
                    if (fmt_resp_reg) begin
                        res_grant_next  = '0;
                        res_status_next = bba_pkg::STAT_OK;
                        state_next      = S_RESP;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE: begin
                if (s_tvalid) begin
                    blk_next        = free_blk;
                    res_grant_next  = '0;
                    res_status_next = bba_pkg::STAT_OK;
                    fmt_resp_next   = 1'b0;
                    priority case (s_tuser)
                        bba_pkg::ACT_ALLOC: begin
                            issue_next      = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        bba_pkg::ACT_FREE: begin
                            if (int'(free_blk) < bba_pkg::TOTAL_BITS) begin
                                state_next = S_FREE_RD;
                            end else begin
                                res_status_next = bba_pkg::STAT_RANGE;
                                state_next      = S_RESP;
                            end
                        end
                        bba_pkg::ACT_FORMAT: begin
                            fmt_resp_next = 1'b1;
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // read one word per cycle, test the word read the cycle before
            S_SCAN: begin
                if (pend_valid_reg && bf.hit) begin
                    ram_we          = 1'b1;
                    ram_waddr       = pend_addr_reg;
                    ram_wdata       = bf.cleared;
                    res_grant_next  = bba_pkg::BLOCK_W'(hit_block);
                    res_status_next = bba_pkg::STAT_OK;
                    state_next      = S_RESP;
                end else if (pend_valid_reg &&
                             pend_addr_reg == bba_pkg::WADDR_W'(bba_pkg::SCAN_WORDS - 1)) begin
                    res_grant_next  = '0;
                    res_status_next = bba_pkg::STAT_FULL;
                    state_next      = S_RESP;
                end else if (issue_reg < bba_pkg::SCNT_W'(bba_pkg::SCAN_WORDS)) begin
                    ram_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_addr_next  = bba_pkg::WADDR_W'(issue_reg);
                    issue_next      = issue_reg + bba_pkg::SCNT_W'(1);
                end else begin
                    pend_valid_next = 1'b0;
                end
            end

            S_FREE_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = bba_pkg::WADDR_W'(blk_reg >> bba_pkg::BIT_W);
                state_next = S_FREE_WR;
            end

            S_FREE_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = bba_pkg::WADDR_W'(blk_reg >> bba_pkg::BIT_W);
                ram_wdata  = ram_rdata | free_bit;
                state_next = S_RESP;
            end

            // hand the result to the output register once it is free
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_grant_next  = res_grant_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            fmt_resp_reg   <= 1'b0;
            clr_addr_reg   <= '0;
            issue_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fmt_resp_reg   <= fmt_resp_next;
            clr_addr_reg   <= clr_addr_next;
            issue_reg      <= issue_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        blk_reg        <= blk_next;
        res_grant_reg  <= res_grant_next;
        res_status_reg <= res_status_next;
        pend_addr_reg  <= pend_addr_next;
        m_grant_reg    <= m_grant_next;
        m_status_reg   <= m_status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(16 - bba_pkg::BLOCK_W){1'b0}}, m_grant_reg};
    assign m_tuser  = m_status_reg;

    // a taken request holds off the next one: the block is not ready in the cycle after
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a failed request never reports a grant
    a_no_grant_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != bba_pkg::STAT_OK) |-> (m_tdata == '0))
        else $error("grant reported with error status");

    // an allocation clears exactly one free bit
    a_alloc_one_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && (state_reg == S_SCAN) |->
            ($countones(ram_wdata) + 1 == $countones(scan_word)) && (ram_wdata != '0 ||
             $countones(scan_word) == 1))
        else $error("allocation changed more than one bit");

    // a free sets at most one bit and clears none
    a_free_one_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && (state_reg == S_FREE_WR) |->
            ($countones(ram_wdata & ~ram_rdata) <= 1) && ((ram_rdata & ~ram_wdata) == '0))
        else $error("free changed the map beyond one bit");

endmodule

// ===== rtl/bba_ram.sv =====
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bba_bitfind.sv =====
module bba_bitfind (
    input  logic [bba_pkg::WORD_W-1:0] word,
    output bba_pkg::bf_res_t           res
);

    logic [bba_pkg::WORD_W-1:0] low;
    logic [bba_pkg::BIT_W-1:0]  idx;

    // isolate the lowest set bit, then encode its position
    always_comb begin
        low = word & (~word + bba_pkg::WORD_W'(1));
        idx = '0;
        for (int i = 0; i < bba_pkg::WORD_W; i++) begin
            if (low[i]) begin
                idx = idx | bba_pkg::BIT_W'(i);
            end
        end
        res.hit     = |word;
        res.idx     = idx;
        res.cleared = word & ~low;
    end

endmodule
